/* hdl/i2cm_pkg.sv */
// Shared types and constants for the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

    // Opcodes carried by an input word.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Phase counter and the tick positions that matter.
    localparam int unsigned PHASE_W = 5;
    localparam logic [PHASE_W-1:0] PH_FIRST    = 5'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND   = 5'd2;
    localparam logic [PHASE_W-1:0] PH_LAST_BIT = 5'd15;
    localparam logic [PHASE_W-1:0] PH_ACK_SET  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH = 5'd17;

    // Reset value of the stop-on-NACK register.
    localparam logic STOP_ON_NACK_RST = 1'b1;

    // Command that the sequencer is running.
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       ack_bit;
        logic [7:0] read_data;
        logic       rejected;
    } t_result;

endpackage

`default_nettype wire

/* hdl/i2cm_seq.sv */
// Bus sequencer: state registers and the per-word state update.
`default_nettype none

module i2cm_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [2:0]        i_opcode,
    input  wire logic [7:0]        i_wr_byte,
    input  wire logic              i_send_ack,
    input  wire logic              i_sda_sample,
    input  wire logic              i_stop_on_nack,
    output i2cm_pkg::t_result      o_result
);
    import i2cm_pkg::*;

    t_cmd               r_cmd, n_cmd;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [7:0]         r_shift, n_shift;
    logic               r_ack_choice, n_ack_choice;
    logic               r_ack_seen, n_ack_seen;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;

    logic               busy;
    logic               is_cmd;
    logic [PHASE_W-1:0] p;
    logic               done;
    logic               rej;
    logic [7:0]         rdata;

    assign busy   = (r_cmd != CMD_IDLE);
    assign is_cmd = (i_opcode inside {[OP_START:OP_READ]});
    assign p      = r_phase + PH_FIRST;

    // Next state for one accepted word.
    always_comb begin
        n_cmd        = r_cmd;
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_ack_seen   = r_ack_seen;
        n_scl        = r_scl;
        n_sda        = r_sda;
        done         = 1'b0;
        rej          = 1'b0;
        rdata        = 8'h00;
        if (i_accept) begin
            if (is_cmd) begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    n_phase = '0;
                    case (i_opcode)
                        OP_START: begin
                            n_cmd = CMD_START;
                            n_sda = 1'b1;
                            n_scl = 1'b1;
                        end
                        OP_STOP: begin
                            n_cmd = CMD_STOP;
                            n_scl = 1'b0;
                            n_sda = 1'b0;
                        end
                        OP_WRITE: begin
                            n_cmd      = CMD_WRITE;
                            n_shift    = i_wr_byte;
                            n_ack_seen = 1'b0;
                            n_sda      = i_wr_byte[7];
                        end
                        default: begin
                            n_cmd        = CMD_READ;
                            n_shift      = 8'h00;
                            n_ack_choice = i_send_ack;
                            n_sda        = 1'b1;
                            n_scl        = 1'b1;
                        end
                    endcase
                end
            end else if (i_opcode == OP_TICK && busy) begin
                n_phase = p;
                case (r_cmd)
                    CMD_START: begin
                        if (p == PH_FIRST) begin
                            n_sda = 1'b0;
                        end else begin
                            n_scl = 1'b0;
                            n_cmd = CMD_IDLE;
                            done  = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        if (p == PH_FIRST) begin
                            n_scl = 1'b1;
                        end else if (p == PH_SECOND) begin
                            n_sda = 1'b1;
                        end else begin
                            n_cmd = CMD_IDLE;
                            done  = 1'b1;
                        end
                    end
                    CMD_WRITE: begin
                        if (p <= PH_ACK_SET) begin
                            if (p[0]) begin
                                n_scl = 1'b1;
                            end else begin
                                n_scl = 1'b0;
                                if (p < PH_ACK_SET) begin
                                    // Shift out the next data bit, MSB first.
                                    n_shift = {r_shift[6:0], 1'b0};
                                    n_sda   = r_shift[6];
                                end else begin
                                    n_sda = 1'b1;
                                end
                            end
                        end else if (p == PH_ACK_HIGH) begin
                            n_scl = 1'b1;
                        end else begin
                            n_ack_seen = i_sda_sample;
                            n_scl      = 1'b0;
                            if (i_sda_sample && i_stop_on_nack) begin
                                // NACK: run a stop right away.
                                n_cmd   = CMD_STOP;
                                n_phase = '0;
                                n_sda   = 1'b0;
                            end else begin
                                n_cmd = CMD_IDLE;
                                done  = 1'b1;
                            end
                        end
                    end
                    CMD_READ: begin
                        if (p <= PH_LAST_BIT) begin
                            if (p[0]) begin
                                n_shift = {r_shift[6:0], i_sda_sample};
                                n_scl   = 1'b0;
                            end else begin
                                n_scl = 1'b1;
                            end
                        end else if (p == PH_ACK_SET) begin
                            n_sda = ~r_ack_choice;
                        end else if (p == PH_ACK_HIGH) begin
                            n_scl = 1'b1;
                        end else begin
                            n_scl = 1'b0;
                            n_cmd = CMD_IDLE;
                            done  = 1'b1;
                            rdata = r_shift;
                        end
                    end
                    default: begin
                        n_cmd = CMD_IDLE;
                    end
                endcase
            end
        end
    end

    // Result word built from the updated state.
    always_comb begin
        o_result.scl_level = n_scl;
        o_result.sda_level = n_sda;
        o_result.busy_res  = (n_cmd != CMD_IDLE);
        o_result.done_res  = done;
        o_result.ack_bit   = n_ack_seen;
        o_result.read_data = rdata;
        o_result.rejected  = rej;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= CMD_IDLE;
            r_phase      <= '0;
            r_shift      <= 8'h00;
            r_ack_choice <= 1'b0;
            r_ack_seen   <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
        end else begin
            r_cmd        <= n_cmd;
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_ack_seen   <= n_ack_seen;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
        end
    end

endmodule

`default_nettype wire

/* hdl/i2cm_out_fifo.sv */
// Two-entry result buffer between the sequencer and the output channel.
`default_nettype none

module i2cm_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire i2cm_pkg::t_result i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_pop_ready,
    output i2cm_pkg::t_result      o_data
);
    import i2cm_pkg::*;

    t_result     r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_pop_ready;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage for waiting words.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/i2c_master_byte_engine_core.sv */
// Top level of the I2C master byte engine.
//
// The input channel carries one word per tick or command: opcode, the byte
// to write, the ACK choice for a read and the SDA level sampled at this tick.
// Each accepted word yields exactly one result word on the output channel
// with the SCL and SDA levels to drive, busy, done, the write acknowledge,
// the byte assembled by a read and a rejected flag for a command that came
// while busy.
// One word is accepted per cycle while the output buffer has room. The state
// update is done in the cycle the word is accepted, and its result is
// registered in a two-entry output buffer, which hands results out in order.
// When the receiver stalls, the buffer holds up to two results; the input
// stays ready until both entries are full.
// Reset (synchronous, active low) releases both bus lines, sets the engine
// idle, empties the buffer and sets stop_on_nack to 1. The stop_on_nack
// register is written through i_cfg_wr_en and i_cfg_wr_data.
`default_nettype none

module i2c_master_byte_engine_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_opcode,
    input  wire logic [7:0] i_wr_byte,
    input  wire logic       i_send_ack,
    input  wire logic       i_sda_sample,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_scl_level,
    output logic            o_sda_level,
    output logic            o_busy_res,
    output logic            o_done_res,
    output logic            o_ack_bit,
    output logic [7:0]      o_read_data,
    output logic            o_rejected
);
    import i2cm_pkg::*;

    logic    r_stop_on_nack;
    logic    accept;
    t_result step_result;
    t_result head;

    assign accept = i_in_valid && o_in_ready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_on_nack <= STOP_ON_NACK_RST;
        end else if (i_cfg_wr_en) begin
            r_stop_on_nack <= i_cfg_wr_data;
        end
    end

    i2cm_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_opcode       (i_opcode),
        .i_wr_byte      (i_wr_byte),
        .i_send_ack     (i_send_ack),
        .i_sda_sample   (i_sda_sample),
        .i_stop_on_nack (r_stop_on_nack),
        .o_result       (step_result)
    );

    i2cm_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (step_result),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (head)
    );

    // Result word fields.
    assign o_scl_level = head.scl_level;
    assign o_sda_level = head.sda_level;
    assign o_busy_res  = head.busy_res;
    assign o_done_res  = head.done_res;
    assign o_ack_bit   = head.ack_bit;
    assign o_read_data = head.read_data;
    assign o_rejected  = head.rejected;

endmodule

`default_nettype wire
